@@ hdl/asod_pkg.sv @@
// Shared types, constants and table functions for the still-orientation detector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package asod_pkg;

    localparam int SMP_W   = 19;
    localparam int TIME_W  = 48;
    localparam int AVG_W   = 32;
    localparam int DISP_W  = 35;   // dispersion never exceeds 8 * 32-bit threshold
    localparam int W_W     = 17;   // Q1.16 weight, saturates at one
    localparam int E_W     = 20;
    localparam int SQ_W    = 40;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    // digit-serial multiplier: signed multiplicand, unsigned multiplier in 8-bit digits
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 32;
    localparam int DIG_W   = 8;
    localparam int N_DIG   = MUL_B_W / DIG_W;
    localparam int CNT_W   = $clog2(N_DIG);
    localparam int ACC_W   = MUL_A_W + DIG_W + 1;
    localparam int HI_W    = MUL_A_W + 1;
    localparam int MUL_P_W = HI_W + MUL_B_W;

    typedef enum logic [IDX_W-1:0] {
        CFG_STILL_THR_SQ  = 3'd0,
        CFG_HOLD_US       = 3'd1,
        CFG_TIMEOUT_US    = 3'd2,
        CFG_EMA_RATE      = 3'd3,
        CFG_ERR_THR       = 3'd4,
        CFG_ONE_G         = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] ST_DETECT  = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [2:0] OR_LEVEL     = 3'd0;
    localparam logic [2:0] OR_LEFT      = 3'd1;
    localparam logic [2:0] OR_RIGHT     = 3'd2;
    localparam logic [2:0] OR_NOSE_DOWN = 3'd3;
    localparam logic [2:0] OR_NOSE_UP   = 3'd4;
    localparam logic [2:0] OR_BACK      = 3'd5;

    localparam logic [2:0] N_CAND = 3'd6;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_START  = 14'b00000000000010,
        S_DT     = 14'b00000000000100,
        S_W      = 14'b00000000001000,
        S_AX     = 14'b00000000010000,
        S_AVG    = 14'b00000000100000,
        S_SQ     = 14'b00000001000000,
        S_DSP    = 14'b00000010000000,
        S_CLAMP  = 14'b00000100000000,
        S_FLAG   = 14'b00001000000000,
        S_DECIDE = 14'b00010000000000,
        S_CLS    = 14'b00100000000000,
        S_TOUT   = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } t_mul_req;

    // candidate order: x +g, x -g, y +g, y -g, z +g, z -g
    function automatic logic [1:0] cand_axis(input logic [2:0] k);
        case (k)
            3'd0, 3'd1: cand_axis = 2'd0;
            3'd2, 3'd3: cand_axis = 2'd1;
            default:    cand_axis = 2'd2;
        endcase
    endfunction

    function automatic logic [2:0] cand_code(input logic [2:0] k);
        case (k)
            3'd0:    cand_code = OR_NOSE_UP;
            3'd1:    cand_code = OR_NOSE_DOWN;
            3'd2:    cand_code = OR_LEFT;
            3'd3:    cand_code = OR_RIGHT;
            3'd4:    cand_code = OR_BACK;
            default: cand_code = OR_LEVEL;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ hdl/accel_still_orientation_detector_unit.sv @@
// A start request goes from acceptance through the start state to the output state. A sample
// computes its weight (no product for zero rate or a gap above 2^32 us), then per axis the
// average, square and dispersion, and when it classifies tests one candidate per cycle. Up to
// ten products on the one shared 8-bit digit-serial multiplier (4 digits each) set the sample time.
// One request at a time, the next taken the cycle after the result registers, later while
// a result waits. Reset (synchronous, active low) restores register defaults and clears the
// detector state and the output valid.
// Top level of the still-orientation detector; depends on asod_pkg, asod_serial_mul.
`timescale 1ns / 1ps
`default_nettype none
module accel_still_orientation_detector_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // time_us[47:0], accel_x[66:48], accel_y[85:67], accel_z[104:86], zero pad
    input  wire logic [111:0]                i_s_tdata,
    // req_type[0]
    input  wire logic                        i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // orientation[2:0], is_still[3], zero pad
    output logic [7:0]                       o_m_tdata,
    // status[1:0]
    output logic [1:0]                       o_m_tuser,
    input  wire logic                        i_cfg_we,
    input  wire logic [asod_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [asod_pkg::CFG_W-1:0]  i_cfg_data
);

    asod_pkg::t_state r_state;

    logic [31:0] r_thr;
    logic [23:0] r_hold_time;
    logic [27:0] r_timeout;
    logic [31:0] r_rate;
    logic [15:0] r_err_thr;
    logic [15:0] r_one_g;

    logic [asod_pkg::TIME_W-1:0]        r_t;
    logic signed [asod_pkg::SMP_W-1:0]  r_smp [3];
    logic signed [asod_pkg::AVG_W-1:0]  r_avg [3];
    logic [asod_pkg::DISP_W-1:0]        r_disp [3];
    logic [asod_pkg::TIME_W-1:0]        r_prev;
    logic [asod_pkg::TIME_W-1:0]        r_still_start;
    logic                               r_running;
    logic [asod_pkg::TIME_W-1:0]        r_deadline;

    logic [asod_pkg::W_W-1:0]           r_w;
    logic [asod_pkg::E_W-1:0]           r_e;
    logic [asod_pkg::SQ_W-1:0]          r_sq;
    logic                               r_all_low;
    logic                               r_any_high;
    logic [1:0]                         r_axis;
    logic [2:0]                         r_k;
    logic [1:0]                         r_status;
    logic [2:0]                         r_orient;

    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [2:0]  r_oorient;
    logic        r_ostill;

    asod_pkg::t_mul_req                    mul_req;
    logic                                  mul_done;
    logic signed [asod_pkg::MUL_P_W-1:0]   mul_p;

    asod_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    logic [asod_pkg::TIME_W-1:0]       n_dt;
    logic                              n_dt_big;
    logic signed [30:0]                n_s;
    logic signed [32:0]                n_dev;
    logic [32:0]                       n_abs;
    logic [48:0]                       n_wp;
    logic [asod_pkg::W_W-1:0]          n_w;
    logic signed [asod_pkg::AVG_W-1:0] n_avg;
    logic [asod_pkg::DISP_W-1:0]       n_disp_dec;
    logic [asod_pkg::DISP_W-1:0]       n_cap;
    logic [asod_pkg::DISP_W-1:0]       n_sqc;
    logic [asod_pkg::DISP_W-1:0]       n_disp_max;
    logic                              n_low;
    logic                              n_high;
    logic [48:0]                       n_still_end;
    logic                              n_long;
    logic [asod_pkg::TIME_W-1:0]       n_dl;
    logic [2:0]                        n_near;
    logic                              n_out_free;

    always_comb begin
        n_dt     = r_t - r_prev;
        n_dt_big = (|n_dt[47:33]) || (n_dt[32] && (|n_dt[31:0]));
        n_s      = {r_smp[0], 12'b0};
        n_dev    = $signed({{2{n_s[30]}}, n_s}) - $signed({r_avg[0][31], r_avg[0]});
        n_abs    = n_dev[32] ? 33'(-n_dev) : 33'(n_dev);
        n_wp     = mul_p[64:16];
        n_w      = (n_wp > 49'h10000) ? 17'h10000 : n_wp[16:0];
        n_avg    = r_avg[0] + mul_p[47:16];
        n_disp_dec = r_disp[0] - mul_p[50:16];
        n_cap    = {r_thr, 3'b0};
        n_sqc    = (r_sq > {5'b0, n_cap}) ? n_cap : r_sq[asod_pkg::DISP_W-1:0];
        n_disp_max = (n_sqc > r_disp[0]) ? n_sqc : r_disp[0];
        n_low    = r_disp[0] < {3'b0, r_thr};
        n_high   = r_disp[0] > {1'b0, r_thr, 2'b0};
        n_still_end = {1'b0, r_still_start} + 49'(r_hold_time);
        n_long   = {1'b0, r_t} > n_still_end;
        n_dl     = r_t + 48'(r_timeout);
        n_out_free = !r_ovalid || i_m_tready;
    end

    // near tests for the current candidate, one per axis
    always_comb begin
        logic signed [33:0] tgt;
        logic signed [33:0] d;
        logic [33:0]        ad;
        for (int i = 0; i < 3; i++) begin
            tgt = '0;
            if (asod_pkg::cand_axis(r_k) == 2'(i)) begin
                tgt = $signed({6'b0, r_one_g, 12'b0});
                if (r_k[0])
                    tgt = -tgt;
            end
            d  = $signed({{2{r_avg[i][31]}}, r_avg[i]}) - tgt;
            ad = d[33] ? 34'(-d) : 34'(d);
            n_near[i] = ad < {6'b0, r_err_thr, 12'b0};
        end
    end

    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = $signed({3'b0, n_dt[32:0]});
        mul_req.b     = r_rate;
        case (r_state)
            asod_pkg::S_DT: begin
                mul_req.start = (r_rate != '0) && !n_dt_big;
            end
            asod_pkg::S_AX: begin
                mul_req.start = 1'b1;
                mul_req.a     = asod_pkg::MUL_A_W'(n_dev);
                mul_req.b     = {15'b0, r_w};
            end
            asod_pkg::S_AVG: begin
                mul_req.start = mul_done;
                mul_req.a     = $signed({16'b0, r_e});
                mul_req.b     = {12'b0, r_e};
            end
            asod_pkg::S_SQ: begin
                mul_req.start = mul_done;
                mul_req.a     = $signed({1'b0, r_disp[0]});
                mul_req.b     = {15'b0, r_w};
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= 32'd65536;
            r_hold_time  <= 24'd1500000;
            r_timeout    <= 28'd30000000;
            r_rate       <= 32'd8590;
            r_err_thr    <= 16'd5120;
            r_one_g      <= 16'd10042;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                asod_pkg::CFG_STILL_THR_SQ:  r_thr        <= i_cfg_data;
                asod_pkg::CFG_HOLD_US:       r_hold_time  <= i_cfg_data[23:0];
                asod_pkg::CFG_TIMEOUT_US:    r_timeout    <= i_cfg_data[27:0];
                asod_pkg::CFG_EMA_RATE:      r_rate       <= i_cfg_data;
                asod_pkg::CFG_ERR_THR:       r_err_thr    <= i_cfg_data[15:0];
                asod_pkg::CFG_ONE_G:         r_one_g      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= asod_pkg::S_IDLE;
            r_prev        <= '0;
            r_still_start <= '0;
            r_running     <= 1'b0;
            r_deadline    <= '0;
            r_ovalid      <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_avg[i]  <= '0;
                r_disp[i] <= '0;
            end
        end else begin
            // the output state reloads the register itself
            if (r_ovalid && i_m_tready && (r_state != asod_pkg::S_OUT))
                r_ovalid <= 1'b0;
            case (r_state)
                asod_pkg::S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_t      <= i_s_tdata[47:0];
                        r_smp[0] <= i_s_tdata[66:48];
                        r_smp[1] <= i_s_tdata[85:67];
                        r_smp[2] <= i_s_tdata[104:86];
                        r_state  <= i_s_tuser ? asod_pkg::S_DT : asod_pkg::S_START;
                    end
                end
                asod_pkg::S_START: begin
                    for (int i = 0; i < 3; i++) begin
                        r_avg[i]  <= '0;
                        r_disp[i] <= '0;
                    end
                    r_prev        <= r_t;
                    r_still_start <= '0;
                    r_running     <= 1'b0;
                    r_deadline    <= n_dl;
                    r_status      <= asod_pkg::ST_DETECT;
                    r_orient      <= asod_pkg::OR_LEVEL;
                    r_state       <= asod_pkg::S_OUT;
                end
                asod_pkg::S_DT: begin
                    r_prev     <= r_t;
                    r_all_low  <= 1'b1;
                    r_any_high <= 1'b0;
                    r_axis     <= '0;
                    if (r_rate == '0) begin
                        r_w     <= '0;
                        r_state <= asod_pkg::S_AX;
                    end else if (n_dt_big) begin
                        r_w     <= 17'h10000;
                        r_state <= asod_pkg::S_AX;
                    end else begin
                        r_state <= asod_pkg::S_W;
                    end
                end
                asod_pkg::S_W: begin
                    if (mul_done) begin
                        r_w     <= n_w;
                        r_state <= asod_pkg::S_AX;
                    end
                end
                asod_pkg::S_AX: begin
                    r_e     <= n_abs[31:12];
                    r_state <= asod_pkg::S_AVG;
                end
                asod_pkg::S_AVG: begin
                    if (mul_done) begin
                        r_avg[0] <= n_avg;
                        r_state  <= asod_pkg::S_SQ;
                    end
                end
                asod_pkg::S_SQ: begin
                    if (mul_done) begin
                        r_sq    <= mul_p[asod_pkg::SQ_W-1:0];
                        r_state <= asod_pkg::S_DSP;
                    end
                end
                asod_pkg::S_DSP: begin
                    if (mul_done) begin
                        r_disp[0] <= n_disp_dec;
                        r_state   <= asod_pkg::S_CLAMP;
                    end
                end
                asod_pkg::S_CLAMP: begin
                    r_disp[0] <= n_disp_max;
                    r_state   <= asod_pkg::S_FLAG;
                end
                asod_pkg::S_FLAG: begin
                    if (!n_low)
                        r_all_low <= 1'b0;
                    if (n_high)
                        r_any_high <= 1'b1;
                    // rotate the axis rings; three turns restore x, y, z order
                    r_avg[0]  <= r_avg[1];
                    r_avg[1]  <= r_avg[2];
                    r_avg[2]  <= r_avg[0];
                    r_disp[0] <= r_disp[1];
                    r_disp[1] <= r_disp[2];
                    r_disp[2] <= r_disp[0];
                    r_smp[0]  <= r_smp[1];
                    r_smp[1]  <= r_smp[2];
                    r_smp[2]  <= r_smp[0];
                    r_axis    <= r_axis + 1'b1;
                    r_state   <= (r_axis == 2'd2) ? asod_pkg::S_DECIDE : asod_pkg::S_AX;
                end
                asod_pkg::S_DECIDE: begin
                    r_k     <= '0;
                    r_state <= asod_pkg::S_TOUT;
                    if (r_all_low) begin
                        if (!r_running) begin
                            r_running     <= 1'b1;
                            r_still_start <= r_t;
                            r_deadline    <= n_dl;
                        end else if (n_long) begin
                            r_state <= asod_pkg::S_CLS;
                        end
                    end else if (r_any_high) begin
                        r_running     <= 1'b0;
                        r_still_start <= '0;
                    end
                end
                asod_pkg::S_CLS: begin
                    if (&n_near) begin
                        r_status <= asod_pkg::ST_FOUND;
                        r_orient <= asod_pkg::cand_code(r_k);
                        r_state  <= asod_pkg::S_OUT;
                    end else if (r_k == asod_pkg::N_CAND - 1'b1) begin
                        r_status <= asod_pkg::ST_INVALID;
                        r_orient <= asod_pkg::OR_LEVEL;
                        r_state  <= asod_pkg::S_OUT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                asod_pkg::S_TOUT: begin
                    r_status <= (r_t > r_deadline) ? asod_pkg::ST_TIMEOUT : asod_pkg::ST_DETECT;
                    r_orient <= asod_pkg::OR_LEVEL;
                    r_state  <= asod_pkg::S_OUT;
                end
                asod_pkg::S_OUT: begin
                    if (n_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_oorient <= r_orient;
                        r_ostill  <= r_running;
                        r_state   <= asod_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= asod_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == asod_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0, r_ostill, r_oorient};
    assign o_m_tuser  = r_ostatus;

endmodule
`default_nettype wire

@@ hdl/asod_serial_mul.sv @@
// Digit-serial signed x unsigned multiplier, one 8-bit digit of b per cycle.
// Depends on asod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module asod_serial_mul (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire asod_pkg::t_mul_req                i_req,
    output logic                                   o_done,
    output logic signed [asod_pkg::MUL_P_W-1:0]    o_p
);

    logic signed [asod_pkg::MUL_A_W-1:0] r_a;
    logic [asod_pkg::MUL_B_W-1:0]        r_b;
    logic signed [asod_pkg::HI_W-1:0]    r_h;
    logic [asod_pkg::MUL_B_W-1:0]        r_l;
    logic [asod_pkg::CNT_W-1:0]          r_cnt;
    logic                                r_busy;
    logic                                r_done;

    logic signed [asod_pkg::ACC_W-1:0]   n_pp;
    logic signed [asod_pkg::ACC_W-1:0]   n_sum;

    always_comb begin
        n_pp  = r_a * $signed({1'b0, r_b[asod_pkg::DIG_W-1:0]});
        n_sum = asod_pkg::ACC_W'(r_h) + n_pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == asod_pkg::CNT_W'(asod_pkg::N_DIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_l <= {n_sum[asod_pkg::DIG_W-1:0], r_l[asod_pkg::MUL_B_W-1:asod_pkg::DIG_W]};
            r_h <= asod_pkg::HI_W'(n_sum >>> asod_pkg::DIG_W);
            r_b <= r_b >> asod_pkg::DIG_W;
        end else if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_h <= '0;
            r_l <= '0;
        end
    end

    assign o_done = r_done;
    assign o_p    = {r_h, r_l};

endmodule
`default_nettype wire

@@ hdl/asod_checker.sv @@
// Port-level checks for the still-orientation detector, bound to the top level.
// Depends on accel_still_orientation_detector_unit ports and asod_pkg codes.
`timescale 1ns / 1ps
`default_nettype none
module asod_port_checks (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [7:0]   o_m_tdata,
    input wire logic [1:0]   o_m_tuser
);

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // one request at a time: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while busy");

    // orientation only reported with a found status, and then a legal code
    a_orient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == asod_pkg::ST_FOUND) ?
            (o_m_tdata[2:0] <= asod_pkg::OR_BACK) : (o_m_tdata[2:0] == asod_pkg::OR_LEVEL))
        else $error("orientation inconsistent with status");

    // no result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind accel_still_orientation_detector_unit asod_port_checks u_asod_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

@@ bench/asod_checker.sv @@
// Watches the request, result and register-write ports of the still-orientation detector,
// predicts every result from its own state copy and compares them. Depends on asod_pkg.
`timescale 1ns / 1ps
module asod_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [111:0] i_s_tdata,
    input  wire logic         i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [7:0]   i_m_tdata,
    input  wire logic [1:0]   i_m_tuser,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data,
    output int                o_fail_cnt,
    output int                o_pending
);

    localparam longint unsigned TMASK = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] orient;
        logic       still;
    } t_verdict;

    t_verdict verdict_q[$];

    // register copy
    longint unsigned thr_sq, hold_us, tout, rate, err_thr, one_g;
    // detector state
    int              avg[3];
    longint unsigned disp[3];
    longint unsigned prev_t, still_start, deadline;
    bit              running;

    function automatic bit near_target(int a, longint tgt);
        longint d;
        d = longint'(a) - tgt * 4096;
        if (d < 0) d = -d;
        return d < longint'(err_thr) * 4096;
    endfunction

    // candidates in priority order: x +g, x -g, y +g, y -g, z +g, z -g
    task automatic classify_gravity(output logic [1:0] st, output logic [2:0] orient);
        int   ax;
        int   sgn;
        bit   ok;
        logic [2:0] code;
        st = asod_pkg::ST_INVALID;
        orient = asod_pkg::OR_LEVEL;
        for (int k = 0; k < 6; k++) begin
            ax  = k / 2;
            sgn = (k % 2 == 0) ? 1 : -1;
            case (k)
                0: code = asod_pkg::OR_NOSE_UP;
                1: code = asod_pkg::OR_NOSE_DOWN;
                2: code = asod_pkg::OR_LEFT;
                3: code = asod_pkg::OR_RIGHT;
                4: code = asod_pkg::OR_BACK;
                default: code = asod_pkg::OR_LEVEL;
            endcase
            ok = 1;
            for (int i = 0; i < 3; i++)
                if (!near_target(avg[i], (i == ax) ? longint'(sgn) * longint'(one_g) : 0))
                    ok = 0;
            if (ok) begin
                st = asod_pkg::ST_FOUND;
                orient = code;
                return;
            end
        end
    endtask

    task automatic predict_request(input logic req, input logic [111:0] d);
        longint unsigned t, dt, w, cap, e, sq;
        longint          s, dev, absd;
        logic signed [18:0] acc;
        bit              all_low, any_high;
        t_verdict        v;
        t = longint'(d[47:0]);
        v = '0;
        if (!req) begin
            for (int i = 0; i < 3; i++) begin
                avg[i] = 0;
                disp[i] = 0;
            end
            prev_t = t;
            still_start = 0;
            running = 0;
            deadline = (t + tout) & TMASK;
        end else begin
            dt = (t - prev_t) & TMASK;
            prev_t = t;
            if (rate == 0) w = 0;
            else if (dt > 64'h1_0000_0000) w = 65536;
            else begin
                w = (dt * rate) >> 16;
                if (w > 65536) w = 65536;
            end
            cap = thr_sq * 8;
            all_low = 1;
            any_high = 0;
            for (int i = 0; i < 3; i++) begin
                acc = d[48 + 19*i +: 19];
                s = longint'(acc) * 4096;
                dev = s - longint'(avg[i]);
                absd = dev < 0 ? -dev : dev;
                e = longint'(absd) >> 12;
                sq = e * e;
                avg[i] = int'(longint'(avg[i]) + ((dev * longint'(w)) >>> 16));
                disp[i] = disp[i] - ((disp[i] * w) >> 16);
                if (sq > cap) sq = cap;
                if (sq > disp[i]) disp[i] = sq;
                if (!(disp[i] < thr_sq)) all_low = 0;
                if (disp[i] > thr_sq * 4) any_high = 1;
            end
            if (all_low) begin
                if (!running) begin
                    running = 1;
                    still_start = t;
                    deadline = (t + tout) & TMASK;
                end else if (t > still_start + hold_us) begin
                    classify_gravity(v.status, v.orient);
                end
            end else if (any_high) begin
                running = 0;
                still_start = 0;
            end
            if (v.status == asod_pkg::ST_DETECT && t > deadline)
                v.status = asod_pkg::ST_TIMEOUT;
        end
        v.still = running;
        verdict_q.push_back(v);
    endtask

    always @(posedge i_clk) begin
        t_verdict exp_v;
        t_verdict got;
        if (!i_rst_n) begin
            thr_sq = 65536; hold_us = 1500000; tout = 30000000;
            rate = 8590; err_thr = 5120; one_g = 10042;
            for (int i = 0; i < 3; i++) begin
                avg[i] = 0;
                disp[i] = 0;
            end
            prev_t = 0; still_start = 0; running = 0; deadline = 0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    asod_pkg::CFG_STILL_THR_SQ: thr_sq = i_cfg_data;
                    asod_pkg::CFG_HOLD_US:      hold_us = i_cfg_data[23:0];
                    asod_pkg::CFG_TIMEOUT_US:   tout = i_cfg_data[27:0];
                    asod_pkg::CFG_EMA_RATE:     rate = i_cfg_data;
                    asod_pkg::CFG_ERR_THR:      err_thr = i_cfg_data[15:0];
                    asod_pkg::CFG_ONE_G:        one_g = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tuser;
                got.orient = i_m_tdata[2:0];
                got.still  = i_m_tdata[3];
                if (verdict_q.size() == 0) begin
                    o_fail_cnt <= o_fail_cnt + 1;
                    if (o_fail_cnt < 10)
                        $display("unexpected result: status %0d orient %0d still %0d",
                                 got.status, got.orient, got.still);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (got !== exp_v) begin
                        o_fail_cnt <= o_fail_cnt + 1;
                        if (o_fail_cnt < 10)
                            $display("mismatch: exp %0d %0d %0d, got %0d %0d %0d",
                                     exp_v.status, exp_v.orient, exp_v.still,
                                     got.status, got.orient, got.still);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) predict_request(i_s_tuser, i_s_tdata);
        end
        o_pending <= verdict_q.size();
    end

    initial begin
        o_fail_cnt = 0;
        o_pending = 0;
    end

endmodule

@@ bench/tb_accel_still_orientation_detector_unit.sv @@
// Stimulus and verdict for the still-orientation detector: register phases, start/sample
// sequences with random gaps and stalls. Depends on asod_pkg, asod_checker and the block.
`timescale 1ns / 1ps
module tb_accel_still_orientation_detector_unit;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [7:0]   m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we = 0;
    logic [2:0]   cfg_idx = '0;
    logic [31:0]  cfg_data = '0;
    int           fail_cnt, pending;

    int           n_sent = 0, n_recv = 0;
    int           send_idle_pct = 0, recv_stall_pct = 0;
    bit           hold_off = 0;
    logic [47:0]  now_us = 0;
    int           cur_one_g = 10042;

    accel_still_orientation_detector_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    asod_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_tvalid && m_tready) n_recv <= n_recv + 1;

    task automatic send_request(input logic req, input logic [47:0] t,
                                input int ax, input int ay, input int az);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, 19'(az), 19'(ay), 19'(ax), t};
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (n_recv != n_sent) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input asod_pkg::t_cfg_idx idx, input logic [31:0] val);
        cfg_we   <= 1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        if (idx == asod_pkg::CFG_ONE_G) cur_one_g = val[15:0];
    endtask

    task automatic write_all(input logic [31:0] thr, input logic [31:0] st,
                             input logic [31:0] to, input logic [31:0] rt,
                             input logic [31:0] er, input logic [31:0] g);
        write_reg(asod_pkg::CFG_STILL_THR_SQ, thr);
        write_reg(asod_pkg::CFG_HOLD_US, st);
        write_reg(asod_pkg::CFG_TIMEOUT_US, to);
        write_reg(asod_pkg::CFG_EMA_RATE, rt);
        write_reg(asod_pkg::CFG_ERR_THR, er);
        write_reg(asod_pkg::CFG_ONE_G, g);
        cfg_we <= 0;
    endtask

    function automatic int noisy(input int base, input int amp);
        int v;
        v = base + $urandom_range(2 * amp) - amp;
        if (v > 262143) v = 262143;
        if (v < -262144) v = -262144;
        return v;
    endfunction

    // start request, then a run of samples held at one attitude with small noise, some at random
    task automatic still_run(input int n);
        int g[3];
        int amp, k;
        g = '{0, 0, 0};
        k = $urandom_range(6);
        if (k < 6) g[k / 2] = (k % 2 == 0) ? cur_one_g : -cur_one_g;
        else foreach (g[i]) g[i] = $urandom_range(20000) - 10000;
        amp = $urandom_range(3) == 0 ? 400 : $urandom_range(120);
        now_us += 48'($urandom_range(5000));
        send_request(0, now_us, $urandom_range(524287) - 262144, 0, 0);
        for (int j = 0; j < n; j++) begin
            case ($urandom_range(19))
                0: now_us = 48'({$urandom, $urandom});
                1: now_us -= 48'($urandom_range(100000));
                2: now_us += 48'($urandom_range(200000));
                default: now_us += 48'($urandom_range(3000) + 1);
            endcase
            if ($urandom_range(14) == 0)
                send_request(1, now_us, $urandom_range(524287) - 262144,
                             $urandom_range(524287) - 262144, $urandom_range(524287) - 262144);
            else
                send_request(1, now_us, noisy(g[0], amp), noisy(g[1], amp), noisy(g[2], amp));
        end
    endtask

    initial begin
        int budget;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: sample before any start, extremes, wrapped deadline, backward time
        send_request(1, 48'd5, 0, 0, 0);
        send_request(1, 48'd10, 262143, -262144, 262143);
        send_request(1, 48'hFFFF_FFFF_FFFF, -262144, 262143, -262144);
        send_request(0, 48'hFFFF_FFFF_FF00, 0, 0, 0);
        send_request(1, 48'hFFFF_FFFF_FFFF, 0, 0, 10042);
        send_request(1, 48'd3, 0, 0, 10042);
        wait_drained();
        write_all(65536, 0, 500000, 32'hFFFF_FFFF, 5120, 10042);
        send_request(0, 48'd1000, 0, 0, 0);
        for (int k = 0; k < 6; k++) begin
            int v[3];
            v = '{0, 0, 0};
            v[k / 2] = (k % 2 == 0) ? 10042 : -10042;
            send_request(1, 48'd2000 + 48'(k * 30), v[0], v[1], v[2]);
            send_request(1, 48'd2010 + 48'(k * 30), v[0], v[1], v[2]);
        end
        send_request(1, 48'd3000, 5000, 5000, 5000);
        send_request(1, 48'd3001, 5000, 5000, 5000);
        send_request(1, 48'd2999, 262143, 262143, 262143);
        send_request(1, 48'd600000, 0, 0, -10042);
        wait_drained();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: write_all(65536, 2000, 200000, 3000000, 5120, 10042);
                1: write_all(0, 0, 0, 32'hFFFF_FFFF, 0, 0);
                2: write_all(32'hFFFF_FFFF, 24'hFF_FFFF, 28'hFFF_FFFF, 0, 16'hFFFF, 16'hFFFF);
                default: write_all($urandom_range(1 << 20, 4096), $urandom_range(5000),
                                   $urandom_range(400000), $urandom_range(20000000, 100000),
                                   $urandom_range(8000, 100), $urandom_range(12000, 8000));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (ph == 3) hold_off = 1;
            budget = 180;
            while (budget > 0) begin
                int n;
                n = $urandom_range(50, 15);
                still_run(n);
                budget -= n + 1;
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
